@@ sv/kmc_pkg.sv @@
// Package for the k-mer counter: sizes, opcodes, parser modes and character codes.
// Helper functions for word length, masks and table bounds.
// No dependencies.
package kmc_pkg;

    localparam int MAX_WORD_LENGTH = 6;
    localparam int COUNT_WIDTH = 32;
    localparam int ADDR_W = 2 * MAX_WORD_LENGTH + 1;
    localparam int MASK_W = 2 * MAX_WORD_LENGTH;
    localparam int LEN_W = $clog2(MAX_WORD_LENGTH + 1);
    localparam int CFG_LEN_W = 3;
    localparam int S_TDATA_W = 24;
    localparam int APB_ADDR_W = 3;

    typedef enum logic [1:0] {
        OP_TEXT   = 2'd0,
        OP_FINISH = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_HEADER  = 2'd1,
        MODE_SEGMENT = 2'd2
    } t_mode;

    localparam logic [2:0] CLS_SKIP = 3'd4;
    localparam logic [2:0] CLS_BREAK = 3'd5;

    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UC = 8'h43;
    localparam logic [7:0] CH_UG = 8'h47;
    localparam logic [7:0] CH_UT = 8'h54;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LC = 8'h63;
    localparam logic [7:0] CH_LG = 8'h67;
    localparam logic [7:0] CH_LT = 8'h74;
    localparam logic [7:0] CH_GT = 8'h3e;
    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] wl);
        logic [LEN_W-1:0] k;
        if (wl == '0) begin
            k = LEN_W'(1);
        end else if (int'(wl) > MAX_WORD_LENGTH) begin
            k = LEN_W'(MAX_WORD_LENGTH);
        end else begin
            k = LEN_W'(wl);
        end
        return k;
    endfunction

    function automatic logic [2:0] letter_class(input logic [7:0] b);
        logic [2:0] c;
        case (b)
            CH_UA, CH_LA: c = 3'd0;
            CH_UC, CH_LC: c = 3'd1;
            CH_UG, CH_LG: c = 3'd2;
            CH_UT, CH_LT: c = 3'd3;
            CH_LF, CH_TAB, CH_SPACE, CH_DASH: c = CLS_SKIP;
            default: c = CLS_BREAK;
        endcase
        return c;
    endfunction

    function automatic logic [MASK_W-1:0] mask_of(input logic [LEN_W-1:0] len);
        return MASK_W'((64'd1 << (2 * len)) - 64'd1);
    endfunction

    function automatic logic [ADDR_W-1:0] fold_top(input logic [LEN_W-1:0] len);
        return ADDR_W'((64'd2 << (2 * len)) - 64'd1);
    endfunction

    function automatic logic [ADDR_W-1:0] fold_low(input logic [LEN_W-1:0] len);
        return ADDR_W'(64'd1 << (2 * len));
    endfunction

    function automatic logic [ADDR_W:0] read_limit(input logic [LEN_W-1:0] len);
        return (ADDR_W + 1)'(64'd2 << (2 * len));
    endfunction

endpackage

@@ sv/kmc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module kmc_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/kmc_seq.sv @@
// Sequencer of the k-mer counter: parser, window, table updates, flush, fold and reads.
// Depends on kmc_pkg and kmc_ram.
module kmc_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [kmc_pkg::LEN_W-1:0]       i_len,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [kmc_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // char_byte, read_index, zero pad
    input  logic [1:0]                      s_axis_tuser,  // opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [kmc_pkg::COUNT_WIDTH-1:0] m_axis_tdata,  // count
    output logic                            m_axis_tuser   // status
);
    import kmc_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_BUMP_RD = 13'b0000000000100,
        S_BUMP_WR = 13'b0000000001000,
        S_FL_TRIM = 13'b0000000010000,
        S_FL_RD   = 13'b0000000100000,
        S_FL_WR   = 13'b0000001000000,
        S_FD_RS   = 13'b0000010000000,
        S_FD_RT   = 13'b0000100000000,
        S_FD_WR   = 13'b0001000000000,
        S_READ_RD = 13'b0010000000000,
        S_READ_DT = 13'b0100000000000,
        S_RESULT  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    t_mode r_mode, n_mode;
    t_op r_op, n_op;
    logic [7:0] r_byte, n_byte;
    logic [ADDR_W-1:0] r_window, n_window;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [LEN_W-1:0] r_len, n_len;
    logic [COUNT_WIDTH-1:0] r_sval, n_sval;
    logic [COUNT_WIDTH-1:0] r_res_count, n_res_count;
    logic r_res_status, n_res_status;
    logic r_out_valid, n_out_valid;
    logic [COUNT_WIDTH-1:0] r_out_count, n_out_count;
    logic r_out_status, n_out_status;

    logic ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

    logic accept;
    t_op in_op;
    logic [7:0] in_byte;
    logic [ADDR_W-1:0] in_idx;
    logic [2:0] cls;
    logic [MASK_W-1:0] cur_mask;
    logic [ADDR_W-1:0] base_w;
    logic [ADDR_W+1:0] shifted, mask_ext;
    logic need_bump;
    logic [ADDR_W-1:0] next_w;
    logic [ADDR_W-1:0] fl_addr;
    logic [COUNT_WIDTH:0] fold_sum;
    logic fl_done;

    kmc_ram #(.DATA_W(COUNT_WIDTH), .ADDR_W(ADDR_W)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign in_op = t_op'(s_axis_tuser);
    assign in_byte = s_axis_tdata[7:0];
    assign in_idx = s_axis_tdata[ADDR_W+7:8];
    assign cls = letter_class(in_byte);
    assign cur_mask = mask_of(i_len);
    assign base_w = (r_mode == MODE_SEGMENT) ? r_window : ADDR_W'(1);
    assign shifted = {base_w, cls[1:0]};
    assign mask_ext = (ADDR_W + 2)'(cur_mask);
    assign need_bump = ((ADDR_W + 2)'(base_w) > mask_ext);
    assign next_w = need_bump ? ADDR_W'((shifted & mask_ext) + mask_ext + (ADDR_W + 2)'(1))
                              : ADDR_W'(shifted);
    assign fl_addr = (r_window & ADDR_W'(r_mask)) + ADDR_W'(r_mask) + ADDR_W'(1);
    assign fold_sum = {1'b0, ram_rdata} + {1'b0, r_sval};

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_count;
    assign m_axis_tuser = r_out_status;

    always_comb begin
        n_state = r_state;
        n_mode = r_mode;
        n_op = r_op;
        n_byte = r_byte;
        n_window = r_window;
        n_addr = r_addr;
        n_mask = r_mask;
        n_len = r_len;
        n_sval = r_sval;
        n_res_count = r_res_count;
        n_res_status = r_res_status;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_count = r_out_count;
        n_out_status = r_out_status;
        ram_we = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_re = 1'b0;
        ram_raddr = r_addr;
        fl_done = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op = in_op;
                    n_byte = in_byte;
                    n_res_count = '0;
                    n_res_status = 1'b0;
                    n_state = S_RESULT;
                    case (in_op)
                        OP_TEXT: begin
                            unique case (r_mode)
                                MODE_HEADER: begin
                                    if (in_byte == CH_LF) begin
                                        n_mode = MODE_BETWEEN;
                                    end
                                end
                                MODE_SEGMENT: begin
                                    if (cls < CLS_SKIP) begin
                                        n_window = next_w;
                                        if (need_bump) begin
                                            n_addr = r_window;
                                            n_state = S_BUMP_RD;
                                        end
                                    end else if (cls == CLS_BREAK) begin
                                        n_mask = cur_mask;
                                        n_state = S_FL_TRIM;
                                    end
                                end
                                default: begin
                                    if (in_byte == CH_GT) begin
                                        n_mode = MODE_HEADER;
                                    end else if (cls < CLS_SKIP) begin
                                        n_mode = MODE_SEGMENT;
                                        n_window = next_w;
                                    end
                                end
                            endcase
                        end
                        OP_FINISH: begin
                            if (r_mode == MODE_SEGMENT) begin
                                n_mask = cur_mask;
                                n_state = S_FL_TRIM;
                            end else begin
                                n_mode = MODE_BETWEEN;
                                n_window = ADDR_W'(1);
                                n_len = i_len;
                                n_addr = fold_top(i_len);
                                n_state = S_FD_RS;
                            end
                        end
                        OP_READ: begin
                            if (in_idx == '0 || {1'b0, in_idx} >= read_limit(i_len)) begin
                                n_res_status = 1'b1;
                            end else begin
                                n_addr = in_idx;
                                n_state = S_READ_RD;
                            end
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_BUMP_RD: begin
                ram_re = 1'b1;
                n_state = S_BUMP_WR;
            end
            S_BUMP_WR: begin
                ram_we = 1'b1;
                ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
                n_state = S_RESULT;
            end
            S_FL_TRIM: begin
                if (ADDR_W'(r_mask) > r_window) begin
                    n_mask = r_mask >> 2;
                end else if (r_mask == '0) begin
                    fl_done = 1'b1;
                end else begin
                    n_state = S_FL_RD;
                end
            end
            S_FL_RD: begin
                ram_re = 1'b1;
                ram_raddr = fl_addr;
                n_addr = fl_addr;
                n_state = S_FL_WR;
            end
            S_FL_WR: begin
                ram_we = 1'b1;
                ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
                n_mask = r_mask >> 2;
                if ((r_mask >> 2) == '0) begin
                    fl_done = 1'b1;
                end else begin
                    n_state = S_FL_RD;
                end
            end
            S_FD_RS: begin
                ram_re = 1'b1;
                n_state = S_FD_RT;
            end
            S_FD_RT: begin
                ram_re = 1'b1;
                ram_raddr = r_addr >> 2;
                n_sval = ram_rdata;
                n_state = S_FD_WR;
            end
            S_FD_WR: begin
                ram_we = 1'b1;
                ram_waddr = r_addr >> 2;
                ram_wdata = fold_sum[COUNT_WIDTH] ? '1 : fold_sum[COUNT_WIDTH-1:0];
                if (r_addr == fold_low(r_len)) begin
                    if (r_len == LEN_W'(1)) begin
                        n_state = S_RESULT;
                    end else begin
                        n_len = r_len - LEN_W'(1);
                        n_addr = fold_top(r_len - LEN_W'(1));
                        n_state = S_FD_RS;
                    end
                end else begin
                    n_addr = r_addr - ADDR_W'(1);
                    n_state = S_FD_RS;
                end
            end
            S_READ_RD: begin
                ram_re = 1'b1;
                n_state = S_READ_DT;
            end
            S_READ_DT: begin
                n_res_count = ram_rdata;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_res_count;
                    n_out_status = r_res_status;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fl_done) begin
            n_window = ADDR_W'(1);
            if (r_op == OP_FINISH) begin
                n_mode = MODE_BETWEEN;
                n_len = i_len;
                n_addr = fold_top(i_len);
                n_state = S_FD_RS;
            end else begin
                n_mode = (r_byte == CH_GT) ? MODE_HEADER : MODE_BETWEEN;
                n_state = S_RESULT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode <= MODE_BETWEEN;
            r_window <= ADDR_W'(1);
            r_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode <= n_mode;
            r_window <= n_window;
            r_addr <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_byte <= n_byte;
        r_mask <= n_mask;
        r_len <= n_len;
        r_sval <= n_sval;
        r_res_count <= n_res_count;
        r_res_status <= n_res_status;
        r_out_count <= n_out_count;
        r_out_status <= n_out_status;
    end
endmodule

@@ sv/dna_kmer_counter.sv @@
// Top level of the k-mer counter: configuration register port and the sequencer.
// Depends on kmc_pkg and kmc_seq.
//
// Input items arrive on the s_axis channel: tuser carries the opcode, tdata the text
// byte and the read index. Each item gives exactly one result on the m_axis channel:
// tdata carries the count and tuser the status flag.
// One item is processed at a time. A text byte that completes a k-mer is counted by a
// read and write of the table. A read fetches one table entry. A segment end trims
// the mask to the window, then reads and writes one entry per counted suffix. A finish
// runs the flush if a segment is open, then folds the entries of each length from k
// down to 1 into their parent entries. The count table has a single read port.
// After reset the table is cleared, one entry per cycle, during which s_axis_tready
// stays low; register writes are taken throughout.
// A result waits in an output register while m_axis_tready is low; the next item is
// accepted meanwhile and its result waits until that register is free. The k-mer
// length register sits at byte address 0; the user writes it only while idle, unenforced.
module dna_kmer_counter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [kmc_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // char_byte, read_index, pad
    input  logic [1:0]                        s_axis_tuser,  // opcode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [kmc_pkg::COUNT_WIDTH-1:0]   m_axis_tdata,  // count
    output logic                              m_axis_tuser,  // status
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kmc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import kmc_pkg::*;

    logic [CFG_LEN_W-1:0] r_kmer_len;
    logic reg_hit;

    assign pready = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == 1'b0);
    assign prdata = reg_hit ? 32'(r_kmer_len) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= CFG_LEN_W'(6);
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_kmer_len <= pwdata[CFG_LEN_W-1:0];
        end
    end

    kmc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_len        (eff_len(r_kmer_len)),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );
endmodule

@@ sv/kmc_checker.sv @@
// Port-level checks for the k-mer counter, bound to the top level.
// Depends on kmc_pkg and dna_kmer_counter.
module kmc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [kmc_pkg::COUNT_WIDTH-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);
    import kmc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("Stalled result changed.");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("Input ready during table clear.");

    a_bad_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("Failed read returned a nonzero count.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Second transaction accepted while busy.");
endmodule

bind dna_kmer_counter kmc_checker u_kmc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

@@ tb/testbench.sv @@
// Self-checking testbench for dna_kmer_counter: directed and random FASTA streams,
// count reads and finish passes, all checked against an in-bench k-mer histogram.
// Depends on kmc_pkg and the dna_kmer_counter RTL.
module testbench;
    import kmc_pkg::*;

    localparam int TABLE_ENTRIES = 1 << ADDR_W;
    localparam longint COUNT_SAT = (64'd1 << COUNT_WIDTH) - 1;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [APB_ADDR_W-1:0] ADDR_KMER_LEN = '0;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic                   status;
    } t_read_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [COUNT_WIDTH-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    dna_kmer_counter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Histogram model state.
    logic [CFG_LEN_W-1:0] model_wl = 3'd6;
    t_mode model_mode = MODE_BETWEEN;
    int unsigned model_window = 1;
    longint model_table [TABLE_ENTRIES];

    t_read_result pending_results [$];
    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;

    function automatic int unsigned word_len();
        if (model_wl == 0) return 1;
        if (model_wl > MAX_WORD_LENGTH) return MAX_WORD_LENGTH;
        return model_wl;
    endfunction

    function automatic int unsigned byte_kind(logic [7:0] b);
        case (b)
            CH_UA, CH_LA: return 0;
            CH_UC, CH_LC: return 1;
            CH_UG, CH_LG: return 2;
            CH_UT, CH_LT: return 3;
            CH_LF, CH_TAB, CH_SPACE, CH_DASH: return CLS_SKIP;
            default: return CLS_BREAK;
        endcase
    endfunction

    function automatic void count_word(int unsigned idx);
        idx = idx & (TABLE_ENTRIES - 1);
        if (model_table[idx] < COUNT_SAT) model_table[idx]++;
    endfunction

    function automatic void push_letter(int unsigned code);
        int unsigned mask;
        int unsigned w;
        mask = (1 << (2 * word_len())) - 1;
        w = model_window;
        if (w > mask) begin
            count_word(w);
            w = (((w << 2) + code) & mask) + mask + 1;
        end else begin
            w = (w << 2) + code;
        end
        model_window = w & (TABLE_ENTRIES - 1);
    endfunction

    function automatic void end_segment();
        int unsigned mask;
        int unsigned w;
        mask = (1 << (2 * word_len())) - 1;
        w = model_window;
        while (mask > w) mask >>= 2;
        while (mask != 0) begin
            w = (w & mask) + mask + 1;
            count_word(w);
            mask >>= 2;
        end
        model_window = 1;
        model_mode = MODE_BETWEEN;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int unsigned kind;
        kind = byte_kind(b);
        if (model_mode == MODE_HEADER) begin
            if (b == CH_LF) model_mode = MODE_BETWEEN;
            return;
        end
        if (model_mode == MODE_SEGMENT) begin
            if (kind < CLS_SKIP) begin
                push_letter(kind);
                return;
            end
            if (kind == CLS_SKIP) return;
            end_segment();
        end
        if (b == CH_GT) begin
            model_mode = MODE_HEADER;
        end else if (kind < CLS_SKIP) begin
            model_window = 1;
            model_mode = MODE_SEGMENT;
            push_letter(kind);
        end
    endfunction

    function automatic void fold_counts();
        int unsigned lo;
        int unsigned t;
        longint add;
        for (int len = word_len(); len >= 1; len--) begin
            lo = 1 << (2 * len);
            for (int s = 2 * lo - 1; s >= lo; s--) begin
                t = s >> 2;
                add = model_table[s];
                if (model_table[t] > COUNT_SAT - add) model_table[t] = COUNT_SAT;
                else model_table[t] += add;
            end
        end
    endfunction

    function automatic t_read_result predict_item(t_op op, logic [7:0] b, logic [12:0] idx);
        t_read_result r;
        int unsigned limit;
        r = '0;
        case (op)
            OP_TEXT: parse_byte(b);
            OP_FINISH: begin
                if (model_mode == MODE_SEGMENT) end_segment();
                model_mode = MODE_BETWEEN;
                model_window = 1;
                fold_counts();
            end
            OP_READ: begin
                limit = 2 << (2 * word_len());
                if (idx == 0 || idx >= limit) r.status = 1'b1;
                else r.count = model_table[idx][COUNT_WIDTH-1:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(t_op op, logic [7:0] b, logic [12:0] idx);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b000, idx, b};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_item(op, b, idx));
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_kmer_len(logic [CFG_LEN_W-1:0] wl);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_KMER_LEN;
        pwdata <= {29'($urandom), wl};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        model_wl = wl;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(OP_TEXT, s[i], '0);
    endtask

    function automatic logic [7:0] fasta_byte();
        int r;
        logic [7:0] letters [8];
        letters = '{CH_UA, CH_UC, CH_UG, CH_UT, CH_LA, CH_LC, CH_LG, CH_LT};
        r = $urandom_range(0, 99);
        if (r < 70) return letters[$urandom_range(0, 7)];
        if (r < 76) return CH_SPACE + 8'($urandom_range(0, 1)) * (CH_DASH - CH_SPACE);
        if (r < 78) return CH_TAB;
        if (r < 81) return CH_GT;
        if (r < 88) return CH_LF;
        return 8'($urandom);
    endfunction

    task automatic test_reset_reads();
        send_item(OP_READ, '0, 13'd0);
        send_item(OP_READ, '0, 13'd8191);
        send_item(OP_READ, '0, 13'd1);
        send_item(OP_NONE, 8'hff, 13'h1fff);
    endtask

    task automatic test_directed_text();
        send_text(">hdr ACGT\nACgtTT a-c\tG\nTTTTTTTTxGA");
        send_item(OP_READ, 8'hff, 13'd4096 + 13'd27);
        send_item(OP_FINISH, '0, '0);
        send_item(OP_READ, '0, 13'd1);
        send_item(OP_READ, '0, 13'd4);
        send_text("CA>in header");
        send_item(OP_FINISH, '0, '0);
        send_item(OP_READ, '0, 13'd5);
    endtask

    task automatic test_kmer_lengths();
        set_kmer_len(3'd1);
        send_text("ACGTTGCA*GG");
        send_item(OP_READ, '0, 13'd7);
        send_item(OP_READ, '0, 13'd8);
        send_item(OP_FINISH, '0, '0);
        send_item(OP_READ, '0, 13'd1);
        set_kmer_len(3'd0);
        send_text("TTAC");
        send_item(OP_READ, '0, 13'd7);
        set_kmer_len(3'd7);
        send_text("GATTACA\n");
        send_item(OP_READ, '0, 13'd8191);
        set_kmer_len(3'd2);
        send_text("CCGG.");
    endtask

    task automatic test_random_stream(int items, logic [CFG_LEN_W-1:0] wl);
        int r;
        int unsigned limit;
        set_kmer_len(wl);
        stall_mode = $urandom_range(0, 3);
        limit = 2 << (2 * word_len());
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 999);
            if (r < 780) send_item(OP_TEXT, fasta_byte(), 13'($urandom));
            else if (r < 940) send_item(OP_READ, 8'($urandom),
                                        13'($urandom_range(1, limit - 1)));
            else if (r < 985) send_item(OP_READ, 8'($urandom), 13'($urandom));
            else if (r < 988) send_item(OP_READ, 8'($urandom), 13'd0);
            else if (r < 997) send_item(OP_NONE, 8'($urandom), 13'($urandom));
            else send_item(OP_FINISH, 8'($urandom), 13'($urandom));
        end
        send_item(OP_FINISH, '0, '0);
        for (int i = 0; i < 8; i++)
            send_item(OP_READ, '0, 13'($urandom_range(1, limit - 1)));
    endtask

    task automatic test_drained_restart();
        send_text("ACGTAC");
        drain_results();
        send_text("GT\n");
        send_item(OP_READ, '0, 13'($urandom_range(1, 8191)));
    endtask

    always @(posedge i_clk) begin
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= (cycles % 5 < 2);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_read_result want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: count %h status %b",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.count || m_axis_tuser !== want.status) begin
                    $display("%0t mismatch: expected count %h status %b, got count %h status %b",
                             $time, want.count, want.status, m_axis_tdata, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        foreach (model_table[i]) model_table[i] = 0;
        burst_left = $urandom_range(1, 20);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_reads();
        test_directed_text();
        test_kmer_lengths();
        test_random_stream(300, 3'd6);
        test_random_stream(250, 3'd1);
        test_drained_restart();
        test_random_stream(250, 3'd3);
        test_random_stream(250, 3'd0);
        test_random_stream(250, 3'd7);
        test_random_stream(250, 3'd2);
        test_random_stream(200, 3'd4);
        test_random_stream(200, 3'd5);
        drain_results();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
